[rtl/dmc_pkg.sv]
// dmc_pkg: shared types, codes and mixing arithmetic for the drive mode controller
package dmc_pkg;

   localparam int unsigned PERIOD_W = 16;
   localparam int unsigned PCT_W    = 7;
   localparam int unsigned MODE_W   = 3;
   localparam int unsigned CMD_W    = 4;

   localparam logic [PERIOD_W-1:0] PERIOD_RESET = 16'd9999;

   // operand width of the shared multiplier
   localparam int unsigned MUL_W   = 24;
   localparam int unsigned PROD1_W = 23;
   // x / 100 == (x * RECIP_100) >> RECIP_SHIFT, exact for x < 2**23
   localparam int unsigned           RECIP_SHIFT = 30;
   localparam logic [MUL_W-1:0]      RECIP_100   = 24'd10737419;

   localparam logic [PCT_W-1:0] DUTY_OFF          = 7'd75;
   localparam logic [PCT_W-1:0] HOPPER_OPEN_PCT   = 7'd95;
   localparam logic [PCT_W-1:0] HOPPER_CLOSED_PCT = 7'd40;
   localparam logic [PCT_W-1:0] IND_PAIRED_PCT    = 7'd40;
   localparam logic [PCT_W-1:0] IND_UNPAIRED_PCT  = 7'd80;

   localparam logic [7:0] NEUTRAL_BYTE = 8'd127;

   localparam logic [MODE_W-1:0] MODE_INIT    = 3'd0;
   localparam logic [MODE_W-1:0] MODE_PAIRING = 3'd1;
   localparam logic [MODE_W-1:0] MODE_IDLE    = 3'd2;
   localparam logic [MODE_W-1:0] MODE_DRIVING = 3'd3;
   localparam logic [MODE_W-1:0] MODE_NOPOWER = 3'd4;

   localparam logic [CMD_W-1:0] EV_INIT     = 4'd0;
   localparam logic [CMD_W-1:0] EV_PAIRED   = 4'd1;
   localparam logic [CMD_W-1:0] EV_IDLE     = 4'd2;
   localparam logic [CMD_W-1:0] EV_COMMAND  = 4'd3;
   localparam logic [CMD_W-1:0] EV_UNPAIRED = 4'd4;
   localparam logic [CMD_W-1:0] EV_CHARGE   = 4'd5;
   localparam logic [CMD_W-1:0] EV_DUMP     = 4'd6;
   localparam logic [CMD_W-1:0] EV_NOPOWER  = 4'd7;

   typedef struct packed {
      logic [MODE_W-1:0] mode;
      logic [PCT_W-1:0]  left_duty;
      logic [PCT_W-1:0]  right_duty;
      logic              hopper_open;
      logic              paired_mark;
   } dmc_state_type;

   typedef struct packed {
      logic [PCT_W-1:0] left_duty;
      logic [PCT_W-1:0] right_duty;
   } dmc_duty_type;

   // duty = 75 + floor(4*q/5), q = trunc(30*(s-127)/255)
   function automatic logic [PCT_W-1:0] side_duty(input logic [7:0] s);
      logic        neg;
      logic [7:0]  mag;
      logic [11:0] x;
      logic [11:0] xq;
      logic [3:0]  q;
      logic [5:0]  num;
      logic [9:0]  prod;
      logic [3:0]  f;
      neg  = (s < NEUTRAL_BYTE);
      mag  = neg ? (NEUTRAL_BYTE - s) : (s - NEUTRAL_BYTE);
      x    = 12'(mag) * 12'd30;
      // divide by 255, exact for every x here (up to 128*30)
      xq   = x + 12'd1 + (x >> 8);
      q    = xq[11:8];
      // floor of a negative quotient rounds the magnitude up
      num  = neg ? ({q, 2'b00} + 6'd4) : {q, 2'b00};
      prod = 10'(num) * 10'd13;
      f    = prod[9:6];
      return neg ? (DUTY_OFF - 7'(f)) : (DUTY_OFF + 7'(f));
   endfunction

   function automatic dmc_duty_type mix(input logic [7:0] v, input logic [7:0] w);
      logic signed [9:0] ls;
      logic signed [9:0] rs;
      logic [7:0]        lc;
      logic [7:0]        rc;
      dmc_duty_type      d;
      ls = $signed({2'b00, v}) + $signed({2'b00, w}) - 10'sd127;
      rs = $signed({2'b00, v}) - $signed({2'b00, w}) + 10'sd127;
      lc = (ls < 0) ? 8'd0 : ((ls > 10'sd255) ? 8'd255 : ls[7:0]);
      rc = (rs < 0) ? 8'd0 : ((rs > 10'sd255) ? 8'd255 : rs[7:0]);
      if (v == NEUTRAL_BYTE && w == NEUTRAL_BYTE) begin
         d.left_duty  = DUTY_OFF;
         d.right_duty = DUTY_OFF;
      end else if (v >= NEUTRAL_BYTE) begin
         d.left_duty  = side_duty(lc);
         d.right_duty = side_duty(rc);
      end else begin
         d.left_duty  = side_duty(rc);
         d.right_duty = side_duty(lc);
      end
      return d;
   endfunction

endpackage

[rtl/differential_drive_mode_controller.sv]
// differential_drive_mode_controller: event sequencer with one shared multiplier for compares
// sequence: an accepted req word passes a state update, 4 compares x 2 passes through the shared
//   24x24 multiplier and an output load before rsp_tvalid; the load waits while rsp is stalled
// events: one at a time; a new req word is taken only in idle, after the last result is
//   loaded; a finished word waits in the rsp register while the next event is taken
// reset: synchronous, active high; mode init, duties 75, hopper closed, unpaired, period 9999
module differential_drive_mode_controller (
   input  logic                                clock,
   input  logic                                reset,
   input  logic                                req_tvalid,
   output logic                                req_tready,
   input  logic [23:0]                         req_tdata,  // velocity, omega, power_present, pad
   input  logic [dmc_pkg::CMD_W-1:0]           req_tuser,  // cmd
   output logic                                rsp_tvalid,
   input  logic                                rsp_tready,
   // left_compare, right_compare, hopper_compare, indicator_compare, mode, pad
   output logic [71:0]                         rsp_tdata,
   input  logic                                csr_valid,
   output logic                                csr_ready,
   input  logic [dmc_pkg::PERIOD_W-1:0]        csr_data
);
   import dmc_pkg::*;

   localparam logic [2:0] S_IDLE = 3'd0;
   localparam logic [2:0] S_UPD  = 3'd1;
   localparam logic [2:0] S_MUL1 = 3'd2;
   localparam logic [2:0] S_MUL2 = 3'd3;
   localparam logic [2:0] S_HOLD = 3'd4;

   logic [2:0]          state_ff, state_in;
   logic [1:0]          idx_ff, idx_in;
   logic [PERIOD_W-1:0] period_ff;
   logic [CMD_W-1:0]    cmd_ff;
   logic [7:0]          velocity_ff;
   logic [7:0]          omega_ff;
   logic                power_ff;
   logic [PROD1_W-1:0]  prod_ff;
   logic [PERIOD_W-1:0] cmp_ff [4];
   logic                rsp_valid_ff;
   logic [71:0]         rsp_data_ff;

   dmc_state_type       st;
   logic                upd;
   logic                req_accept;
   logic                load_rsp;
   logic [PCT_W-1:0]    pct;
   logic [MUL_W-1:0]    mul_a, mul_b;
   logic [2*MUL_W-1:0]  mul_p;

   assign req_accept = req_tvalid && req_tready;
   assign req_tready = (state_ff == S_IDLE);
   assign csr_ready  = 1'b1;
   assign upd        = (state_ff == S_UPD);
   assign load_rsp   = (state_ff == S_HOLD) && (!rsp_valid_ff || rsp_tready);

   dmc_mode_fsm u_fsm (
      .clock         (clock),
      .reset         (reset),
      .upd           (upd),
      .cmd           (cmd_ff),
      .velocity      (velocity_ff),
      .omega         (omega_ff),
      .power_present (power_ff),
      .st            (st)
   );

   always_comb begin
      case (idx_ff)
         2'd0:    pct = st.left_duty;
         2'd1:    pct = st.right_duty;
         2'd2:    pct = st.hopper_open ? HOPPER_OPEN_PCT : HOPPER_CLOSED_PCT;
         default: pct = st.paired_mark ? IND_PAIRED_PCT : IND_UNPAIRED_PCT;
      endcase
   end

   // first pass: period * percent; second pass: scale by the reciprocal of 100
   always_comb begin
      if (state_ff == S_MUL2) begin
         mul_a = MUL_W'(prod_ff);
         mul_b = RECIP_100;
      end else begin
         mul_a = MUL_W'(period_ff);
         mul_b = MUL_W'(pct);
      end
      mul_p = mul_a * mul_b;
   end

   always_comb begin
      state_in = state_ff;
      idx_in   = idx_ff;
      unique case (state_ff)
         S_IDLE: begin
            if (req_accept) state_in = S_UPD;
         end
         S_UPD: begin
            state_in = S_MUL1;
            idx_in   = 2'd0;
         end
         S_MUL1: begin
            state_in = S_MUL2;
         end
         S_MUL2: begin
            idx_in   = idx_ff + 2'd1;
            state_in = (idx_ff == 2'd3) ? S_HOLD : S_MUL1;
         end
         S_HOLD: begin
            if (load_rsp) state_in = S_IDLE;
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         idx_ff       <= 2'd0;
         period_ff    <= PERIOD_RESET;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff <= state_in;
         idx_ff   <= idx_in;
         if (csr_valid && csr_ready) period_ff <= csr_data;
         if (load_rsp) begin
            rsp_valid_ff <= 1'b1;
         end else if (rsp_tready) begin
            rsp_valid_ff <= 1'b0;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (req_accept) begin
         cmd_ff      <= req_tuser;
         velocity_ff <= req_tdata[7:0];
         omega_ff    <= req_tdata[15:8];
         power_ff    <= req_tdata[16];
      end
      if (state_ff == S_MUL1) prod_ff <= mul_p[PROD1_W-1:0];
      if (state_ff == S_MUL2) cmp_ff[idx_ff] <= mul_p[RECIP_SHIFT+PERIOD_W-1:RECIP_SHIFT];
      if (load_rsp) begin
         rsp_data_ff <= {5'd0, st.mode, cmp_ff[3], cmp_ff[2], cmp_ff[1], cmp_ff[0]};
      end
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = rsp_data_ff;

endmodule

[rtl/dmc_mode_fsm.sv]
// dmc_mode_fsm: five-mode controller state, duty percents, hopper and pairing marks
module dmc_mode_fsm (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          upd,
   input  logic [dmc_pkg::CMD_W-1:0]     cmd,
   input  logic [7:0]                    velocity,
   input  logic [7:0]                    omega,
   input  logic                          power_present,
   output dmc_pkg::dmc_state_type        st
);
   import dmc_pkg::*;

   dmc_state_type st_ff;
   dmc_state_type st_in;
   dmc_duty_type  mixed;

   assign mixed = mix(velocity, omega);

   always_comb begin
      st_in = st_ff;
      unique case (st_ff.mode)
         MODE_INIT: begin
            if (cmd == EV_INIT) st_in.mode = MODE_PAIRING;
         end
         MODE_PAIRING: begin
            st_in.paired_mark = 1'b0;
            st_in.left_duty   = DUTY_OFF;
            st_in.right_duty  = DUTY_OFF;
            if (cmd == EV_PAIRED) begin
               st_in.mode        = MODE_IDLE;
               st_in.paired_mark = 1'b1;
            end
         end
         MODE_IDLE: begin
            st_in.left_duty  = DUTY_OFF;
            st_in.right_duty = DUTY_OFF;
            if (cmd == EV_COMMAND) begin
               st_in.left_duty  = mixed.left_duty;
               st_in.right_duty = mixed.right_duty;
               st_in.mode       = MODE_DRIVING;
            end else if (cmd == EV_UNPAIRED) begin
               st_in.paired_mark = 1'b0;
               st_in.mode        = MODE_PAIRING;
            end
         end
         MODE_DRIVING: begin
            if (cmd == EV_IDLE || cmd == EV_CHARGE) begin
               st_in.left_duty  = DUTY_OFF;
               st_in.right_duty = DUTY_OFF;
               st_in.mode       = MODE_IDLE;
            end else if (cmd == EV_COMMAND) begin
               st_in.left_duty  = mixed.left_duty;
               st_in.right_duty = mixed.right_duty;
            end else if (cmd == EV_DUMP) begin
               if (power_present) st_in.hopper_open = ~st_ff.hopper_open;
            end else if (cmd == EV_NOPOWER) begin
               st_in.left_duty  = DUTY_OFF;
               st_in.right_duty = DUTY_OFF;
               st_in.mode       = MODE_NOPOWER;
            end else if (cmd == EV_UNPAIRED) begin
               st_in.left_duty   = DUTY_OFF;
               st_in.right_duty  = DUTY_OFF;
               st_in.paired_mark = 1'b0;
               st_in.mode        = MODE_PAIRING;
            end
         end
         MODE_NOPOWER: begin
            if (cmd == EV_UNPAIRED) begin
               st_in.left_duty   = DUTY_OFF;
               st_in.right_duty  = DUTY_OFF;
               st_in.paired_mark = 1'b0;
               st_in.mode        = MODE_PAIRING;
            end else if (cmd == EV_CHARGE) begin
               st_in.left_duty  = DUTY_OFF;
               st_in.right_duty = DUTY_OFF;
               st_in.mode       = MODE_IDLE;
            end
         end
         default: begin
            st_in = st_ff;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         st_ff.mode        <= MODE_INIT;
         st_ff.left_duty   <= DUTY_OFF;
         st_ff.right_duty  <= DUTY_OFF;
         st_ff.hopper_open <= 1'b0;
         st_ff.paired_mark <= 1'b0;
      end else if (upd) begin
         st_ff <= st_in;
      end
   end

   assign st = st_ff;

endmodule

[rtl/dmc_checker.sv]
// dmc_checker: port-level checks on the drive mode controller, bound to the top level
module dmc_checker (
   input logic                           clock,
   input logic                           reset,
   input logic                           req_tvalid,
   input logic                           req_tready,
   input logic                           rsp_tvalid,
   input logic                           rsp_tready,
   input logic [71:0]                    rsp_tdata
);
   import dmc_pkg::*;

   // one event at a time: no new word right after an accept
   a_busy_after_accept: assert property (@(posedge clock) disable iff (reset)
      (req_tvalid && req_tready) |=> !req_tready)
      else $error("req_tready high right after an accepted word");

   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      (rsp_tvalid && !rsp_tready) |=> (rsp_tvalid && $stable(rsp_tdata)))
      else $error("rsp word changed while stalled");

   a_reset_clears: assert property (@(posedge clock)
      reset |=> !rsp_tvalid)
      else $error("rsp_tvalid high after reset");

   a_mode_range: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid |-> (rsp_tdata[66:64] <= MODE_NOPOWER))
      else $error("reported mode out of range");

   // an accepted word cannot produce a result in the very next cycle
   a_no_instant_rsp: assert property (@(posedge clock) disable iff (reset)
      (req_tvalid && req_tready && !rsp_tvalid) |=> !rsp_tvalid)
      else $error("rsp word appeared too early");

endmodule

bind differential_drive_mode_controller dmc_checker u_dmc_checker (
   .clock      (clock),
   .reset      (reset),
   .req_tvalid (req_tvalid),
   .req_tready (req_tready),
   .rsp_tvalid (rsp_tvalid),
   .rsp_tready (rsp_tready),
   .rsp_tdata  (rsp_tdata)
);
